FILE: sv/lln_pkg.sv
// ----------------------------------------------------------------------------
// lln_pkg
// types and constants shared by the log line character normalizer
// ----------------------------------------------------------------------------
package lln_pkg;

  // character codes
  localparam logic [7:0] NL_CODE    = 8'h0A;
  localparam logic [7:0] SP_CODE    = 8'h20;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // configuration register indexes
  localparam logic [2:0] CFG_LOWER_CASE_MODE = 3'd0;
  localparam logic [2:0] CFG_IGNORE_MAP_LOW  = 3'd1;
  localparam logic [2:0] CFG_IGNORE_MAP_HIGH = 3'd2;
  localparam logic [2:0] CFG_DELIM_MAP_LOW   = 3'd3;
  localparam logic [2:0] CFG_DELIM_MAP_HIGH  = 3'd4;

  // reset values: ignore cr, quotes, parens, brackets and braces; newline is the only delimiter
  localparam logic        RST_LOWER_CASE_MODE = 1'b1;
  localparam logic [63:0] RST_IGNORE_MAP_LOW  = 64'h0000_0384_0000_2000;
  localparam logic [63:0] RST_IGNORE_MAP_HIGH = 64'h2800_0000_2800_0000;
  localparam logic [63:0] RST_DELIM_MAP_LOW   = 64'h0000_0000_0000_0400;
  localparam logic [63:0] RST_DELIM_MAP_HIGH  = 64'h0000_0000_0000_0000;

  // most results one input byte can cause: space, character, terminator
  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic [7:0] in_char;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       seq_end;
    logic       last_of_run;
  } out_item_t;

endpackage

FILE: sv/log_line_char_normalizer_unit.sv
// ----------------------------------------------------------------------------
// log_line_char_normalizer_unit
// byte-wise log text cleaner with space and newline collapsing
// ----------------------------------------------------------------------------
// Takes one log byte per transfer, with line_end on the last byte of a line,
// and gives out cleaned bytes. A byte is optionally lowercased, then dropped
// if its bit is set in the ignore map or turned into a newline if set in the
// delimiter map (both maps cover ASCII only). Repeated newlines and spaces
// collapse, leading and trailing spaces vanish, an empty line gives nothing,
// and a non-empty line closes with a terminator result (seq_end = 1,
// out_char = newline). One input byte causes zero to three results, the
// last flagged with last_of_run. A byte is registered at its input transfer,
// worked out into a burst register, and its results go out one per cycle
// from there while result_ready is high. With the result side always ready
// the block takes a byte every cycle while each byte gives at most one
// result; a byte that gives more results holds the input until the single
// output port has drained the burst register to its last result. Configuration
// writes are always taken (cfg_ready is tied high) and must be made while the
// block is idle; indexes past the last register are ignored.
// ----------------------------------------------------------------------------
module log_line_char_normalizer_unit
  import lln_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input byte channel
  input  logic        item_valid,
  output logic        item_ready,
  input  in_item_t    item,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output out_item_t   result,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // configuration registers
  logic        lower_case_mode;
  logic [63:0] ignore_map_low;
  logic [63:0] ignore_map_high;
  logic [63:0] delim_map_low;
  logic [63:0] delim_map_high;

  // line state
  logic space_pending, space_pending_next;
  logic line_started, line_started_next;
  logic prev_was_newline, prev_was_newline_next;

  // input register
  logic     in_valid;
  in_item_t in_q;

  // burst register: results of one byte, head at entry 0
  out_item_t  burst [MAX_RESULTS];
  logic [1:0] burst_cnt;
  out_item_t  burst_next [MAX_RESULTS];
  logic [1:0] burst_cnt_next;

  logic burst_free;
  logic load;
  logic out_xfer;

  // datapath signals
  logic [7:0]   low_char;
  logic [7:0]   clean_char;
  logic [127:0] ignore_map;
  logic [127:0] delim_map;
  logic         is_ascii;
  logic         ignored;
  logic         delimiter;
  logic         keep;
  logic         is_space;
  logic         emit_space;
  logic         emit_char;
  logic         emit_term;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_case_mode <= RST_LOWER_CASE_MODE;
      ignore_map_low  <= RST_IGNORE_MAP_LOW;
      ignore_map_high <= RST_IGNORE_MAP_HIGH;
      delim_map_low   <= RST_DELIM_MAP_LOW;
      delim_map_high  <= RST_DELIM_MAP_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOWER_CASE_MODE: lower_case_mode <= cfg_data[0];
        CFG_IGNORE_MAP_LOW:  ignore_map_low  <= cfg_data;
        CFG_IGNORE_MAP_HIGH: ignore_map_high <= cfg_data;
        CFG_DELIM_MAP_LOW:   delim_map_low   <= cfg_data;
        CFG_DELIM_MAP_HIGH:  delim_map_high  <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  assign out_xfer     = result_valid && result_ready;
  // burst register can take new results if empty or its last one leaves now
  assign burst_free   = (burst_cnt == 2'd0) || ((burst_cnt == 2'd1) && out_xfer);
  assign load         = in_valid && burst_free;
  assign item_ready   = !in_valid || load;
  assign result_valid = (burst_cnt != 2'd0);
  assign result       = burst[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_ready) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_q <= item;
    end
  end

  // ---------------------------------------------------------------------------
  // character classification
  // ---------------------------------------------------------------------------
  assign ignore_map = {ignore_map_high, ignore_map_low};
  assign delim_map  = {delim_map_high, delim_map_low};

  always_comb begin
    // lowercase only A-Z
    if (lower_case_mode && (in_q.in_char >= UPPER_A) && (in_q.in_char <= UPPER_Z)) begin
      low_char = in_q.in_char + CASE_DELTA;
    end else begin
      low_char = in_q.in_char;
    end
  end

  // bytes of 128 and up are never ignored or mapped
  assign is_ascii   = !low_char[7];
  assign ignored    = is_ascii && ignore_map[low_char[6:0]];
  assign delimiter  = is_ascii && delim_map[low_char[6:0]];
  assign clean_char = delimiter ? NL_CODE : low_char;
  // a newline right after a kept newline collapses
  assign keep       = !ignored && !((clean_char == NL_CODE) && prev_was_newline);
  assign is_space   = (clean_char == SP_CODE);

  assign emit_space = keep && !is_space && space_pending;
  assign emit_char  = keep && !is_space;
  assign emit_term  = in_q.line_end && (line_started || emit_char);

  // ---------------------------------------------------------------------------
  // next line state
  // ---------------------------------------------------------------------------
  always_comb begin
    space_pending_next    = space_pending;
    line_started_next     = line_started;
    prev_was_newline_next = prev_was_newline;
    if (keep) begin
      if (is_space) begin
        // a kept space separates newlines; leading spaces are not held
        prev_was_newline_next = 1'b0;
        if (line_started) begin
          space_pending_next = 1'b1;
        end
      end else begin
        space_pending_next    = 1'b0;
        line_started_next     = 1'b1;
        prev_was_newline_next = (clean_char == NL_CODE);
      end
    end
    // line end clears everything, trailing space is dropped
    if (in_q.line_end) begin
      space_pending_next    = 1'b0;
      line_started_next     = 1'b0;
      prev_was_newline_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      space_pending    <= 1'b0;
      line_started     <= 1'b0;
      prev_was_newline <= 1'b0;
    end else if (load) begin
      space_pending    <= space_pending_next;
      line_started     <= line_started_next;
      prev_was_newline <= prev_was_newline_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result packing: pending space, then character, then terminator
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      burst_next[i] = '{out_char: NL_CODE, seq_end: 1'b0, last_of_run: 1'b0};
    end
    burst_cnt_next = 2'd0;
    if (emit_space) begin
      burst_next[burst_cnt_next] = '{out_char: SP_CODE, seq_end: 1'b0, last_of_run: 1'b0};
      burst_cnt_next = burst_cnt_next + 2'd1;
    end
    if (emit_char) begin
      burst_next[burst_cnt_next] = '{out_char: clean_char, seq_end: 1'b0, last_of_run: 1'b0};
      burst_cnt_next = burst_cnt_next + 2'd1;
    end
    if (emit_term) begin
      burst_next[burst_cnt_next] = '{out_char: NL_CODE, seq_end: 1'b1, last_of_run: 1'b0};
      burst_cnt_next = burst_cnt_next + 2'd1;
    end
    // flag the final result of this byte
    if (burst_cnt_next != 2'd0) begin
      burst_next[burst_cnt_next - 2'd1].last_of_run = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // burst register, drained one result per transfer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_cnt <= 2'd0;
    end else if (load) begin
      burst_cnt <= burst_cnt_next;
    end else if (out_xfer) begin
      burst_cnt <= burst_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        burst[i] <= burst_next[i];
      end
    end else if (out_xfer) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        burst[i] <= burst[i + 1];
      end
    end
  end

endmodule
